FILE: rtl/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types and constants for the CAN multi-frame reassembler.
// ----------------------------------------------------------------------------
package cmr_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int STORE_SLOTS = 8;
    localparam int SLOT_W      = $clog2(STORE_SLOTS);
    localparam int SEEN_W      = 8;
    localparam int EXP_W       = 4;
    localparam int TICK_W      = 17;
    localparam int BASE_W      = 24;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int ID_W        = 29;
    localparam int SEQ_W       = 5;
    localparam int PAYLOAD_W   = 64;
    localparam int WORD_W      = 32;
    localparam int WIDX_W      = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TICK_W-1:0]    TICK_MAX      = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 1'b1;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic step;
        logic word_inc;
    } cmr_cmd_t;

    typedef struct packed {
        logic done_msg;
        logic last;
        logic pair_end;
    } cmr_status_t;

endpackage

FILE: rtl/cmr_in_if.sv
// ----------------------------------------------------------------------------
// cmr_in_if
// Input channel: CAN frame or millisecond tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmr_in_if
    import cmr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ID_W-1:0]      ext_id;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output action, output ext_id, output payload,
                    input ready);
    modport sink   (input valid, input action, input ext_id, input payload,
                    output ready);
endinterface

FILE: rtl/cmr_out_if.sv
// ----------------------------------------------------------------------------
// cmr_out_if
// Output channel: reassembled 32-bit words, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmr_out_if
    import cmr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic              last_word;

    modport source (output valid, output word_index, output word_value,
                    output last_word, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input last_word, output ready);
endinterface

FILE: rtl/cmr_ram.sv
// ----------------------------------------------------------------------------
// cmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cmr_ctrl.sv
// ----------------------------------------------------------------------------
// cmr_ctrl
// Controller: item intake and word drain sequencing.
// ----------------------------------------------------------------------------
module cmr_ctrl
    import cmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        word_valid,
    input  logic        word_ready,
    output cmr_cmd_t    cmd,
    input  cmr_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SHOW  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   word_beat;

    assign item_ready    = (state_reg == ST_IDLE);
    assign word_valid    = (state_reg == ST_SHOW);
    assign word_beat     = word_valid & word_ready;
    assign cmd.step      = item_valid & item_ready;
    assign cmd.word_inc  = word_beat & ~status.last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.step && status.done_msg)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (word_beat)
                begin
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.pair_end)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/cmr_dpath.sv
// ----------------------------------------------------------------------------
// cmr_dpath
// Datapath: config, session tracking, idle counter, store access, word select.
// ----------------------------------------------------------------------------
module cmr_dpath
    import cmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  action,
    input  logic [ID_W-1:0]       ext_id,
    input  logic [PAYLOAD_W-1:0]  payload,
    input  cmr_cmd_t              cmd,
    output cmr_status_t           status,
    output logic                  ram_we,
    output logic [SLOT_W-1:0]     ram_waddr,
    output logic [SLOT_W-1:0]     ram_raddr,
    input  logic [PAYLOAD_W-1:0]  ram_rdata,
    output logic [WIDX_W-1:0]     word_index,
    output logic [WORD_W-1:0]     word_value
);

    logic [BASE_W-1:0]    base_id_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 active_reg, active_next;
    logic [EXP_W-1:0]     expected_reg, expected_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic [WIDX_W-1:0]    word_cnt_reg, word_cnt_next;

    logic                 match;
    logic                 expired;
    logic                 act_eff;
    logic [SEEN_W-1:0]    seen_eff;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     seq_m1;
    logic [7:0]           count;
    logic                 bad_count;
    logic [SEEN_W-1:0]    seq_bit;
    logic [SEEN_W-1:0]    seen_or;
    logic [SEEN_W-1:0]    full;
    logic                 store;
    logic                 done;

    assign match     = (ext_id[ID_W-1:SEQ_W] == base_id_reg);
    assign seq       = ext_id[SEQ_W-1:0];
    assign seq_m1    = seq - SEQ_W'(1);
    assign expired   = active_reg && (ticks_reg > TICK_W'(timeout_reg));
    assign act_eff   = active_reg & ~expired;
    assign seen_eff  = expired ? '0 : seen_reg;
    assign count     = payload[7:0];
    assign bad_count = (count == 8'd0) || (count > 8'(MAX_FRAMES))
                       || (count > 8'(STORE_SLOTS));
    assign seq_bit   = SEEN_W'(1) << seq_m1[SLOT_W-1:0];
    assign seen_or   = seen_eff | seq_bit;

    always_comb
    begin
        for (int k = 0; k < SEEN_W; k++)
        begin
            full[k] = (k < int'(expected_reg));
        end
    end

    assign store = cmd.step && (action == ACT_FRAME) && match && (seq != '0)
                   && act_eff && (seq <= SEQ_W'(expected_reg))
                   && ((seen_eff & seq_bit) == '0);
    assign done  = store && ((seen_or & full) == full);

    always_comb
    begin
        active_next   = active_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        ticks_next    = ticks_reg;
        word_cnt_next = word_cnt_reg;
        if (cmd.step)
        begin
            word_cnt_next = '0;
            if (action == ACT_TICK)
            begin
                if (ticks_reg != TICK_MAX)
                begin
                    ticks_next = ticks_reg + TICK_W'(1);
                end
            end
            else if (match)
            begin
                active_next = act_eff;
                seen_next   = seen_eff;
                if (seq == '0)
                begin
                    if (bad_count)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        expected_next = count[EXP_W-1:0];
                        seen_next     = '0;
                        active_next   = 1'b1;
                        ticks_next    = '0;
                    end
                end
                else if (store)
                begin
                    ticks_next = '0;
                    if (done)
                    begin
                        active_next = 1'b0;
                        seen_next   = '0;
                    end
                    else
                    begin
                        seen_next = seen_or;
                    end
                end
            end
        end
        else if (cmd.word_inc)
        begin
            word_cnt_next = word_cnt_reg + WIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg  <= '0;
            timeout_reg  <= TIMEOUT_RESET;
            active_reg   <= 1'b0;
            expected_reg <= '0;
            seen_reg     <= '0;
            ticks_reg    <= '0;
            word_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_ID:    base_id_reg <= cfg_data[BASE_W-1:0];
                    REG_TIMEOUT_MS: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    default:        ;
                endcase
            end
            active_reg   <= active_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            ticks_reg    <= ticks_next;
            word_cnt_reg <= word_cnt_next;
        end
    end

    assign ram_we    = store;
    assign ram_waddr = seq_m1[SLOT_W-1:0];
    assign ram_raddr = word_cnt_reg[SLOT_W:1];

    assign word_index = word_cnt_reg;
    assign word_value = word_cnt_reg[0] ? ram_rdata[PAYLOAD_W-1:WORD_W]
                                        : ram_rdata[WORD_W-1:0];

    assign status.done_msg = done;
    assign status.last     = ({1'b0, word_cnt_reg} == ({expected_reg, 1'b0} - 5'd1));
    assign status.pair_end = word_cnt_reg[0];

endmodule

FILE: rtl/can_multiframe_reassembler_core.sv
// ----------------------------------------------------------------------------
// can_multiframe_reassembler_core
// Reassembles multi-frame CAN messages into little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Timing: an item is taken in the idle state; a completing frame goes through
//   a fetch state (the store read) before its first word is shown.
// Flow: items that complete nothing are taken back to back; a completed message
//   drains 2*count words, with a fetch per word pair for the registered store read.
// Reset: asynchronous, active low; session cleared, base_id 0, timeout 1000.
//   The frame store is not cleared.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_core
    import cmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cmr_in_if.sink                item_ch,
    cmr_out_if.source             word_ch
);

    cmr_cmd_t             cmd;
    cmr_status_t          status;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [PAYLOAD_W-1:0] ram_rdata;

    cmr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ch.ready),
        .word_valid (word_ch.valid),
        .word_ready (word_ch.ready),
        .cmd        (cmd),
        .status     (status)
    );

    cmr_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (item_ch.action),
        .ext_id     (item_ch.ext_id),
        .payload    (item_ch.payload),
        .cmd        (cmd),
        .status     (status),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .word_index (word_ch.word_index),
        .word_value (word_ch.word_value)
    );

    assign word_ch.last_word = status.last;

    cmr_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (STORE_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_ch.payload),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
